FILE: rtl/sorted_list_table_core_defines.svh
// Shared assertion macros for the sorted list table checks.
`ifndef SORTED_LIST_TABLE_CORE_DEFINES_SVH
`define SORTED_LIST_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define SLT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted list table check failed");

// Next-cycle implication, checked only out of reset.
`define SLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted list table check failed");

`endif

FILE: rtl/slt_pkg.sv
package slt_pkg;

    // Table geometry.
    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    // Field widths of the request and result.
    localparam int CMD_W   = 3;
    localparam int VAL_W   = 32;
    localparam int ST_W    = 2;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP_HEAD = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_TAIL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH   = 3'd4;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic signed [VAL_W-1:0] item_value;
    } t_request;

    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] result_value;
        logic [COUNT_W-1:0]      entry_count;
    } t_result;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic prep;
        logic step;
    } t_dp_ctrl;

    // Datapath to controller status.
    typedef struct packed {
        logic quick;
        logic done;
    } t_dp_stat;

endpackage

FILE: rtl/sorted_list_table_core.sv
// Channel   | Ports                  | Handshake
// ----------+------------------------+---------------------------------------
// request   | i_start, i_request     | taken when i_start is high, o_busy low
// result    | o_strobe, o_result     | valid for the single o_strobe cycle
//
// Each request takes one prep cycle plus a walk over the entry memory, one
// entry per cycle through its single read and write port: insert count-pos+1
// walk cycles, pop tail 1, pop head and remove count, search pos+1 (count on
// a miss). Full, empty and unknown commands finish after the prep cycle.
// The result strobe follows one cycle after the last walk step, and a new
// request may be taken in that strobe cycle. Reset empties the table at once.
// The receiver cannot stall; results are never held back.
module sorted_list_table_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  slt_pkg::t_request i_request,
    output logic              o_busy,
    output logic              o_strobe,
    output slt_pkg::t_result  o_result
);

    slt_pkg::t_dp_ctrl dp_ctrl;
    slt_pkg::t_dp_stat dp_stat;

    // Sequencer.
    slt_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_stat   (dp_stat),
        .o_ctrl   (dp_ctrl),
        .o_busy   (o_busy),
        .o_strobe (o_strobe)
    );

    // Entry memory and walk datapath.
    slt_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_request (i_request),
        .i_ctrl    (dp_ctrl),
        .o_stat    (dp_stat),
        .o_result  (o_result)
    );

endmodule

FILE: rtl/slt_datapath.sv
module slt_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  slt_pkg::t_request i_request,
    input  slt_pkg::t_dp_ctrl i_ctrl,
    output slt_pkg::t_dp_stat o_stat,
    output slt_pkg::t_result  o_result
);

    // Entry storage, ascending from index 0.
    logic signed [slt_pkg::VAL_W-1:0] mem [slt_pkg::DEPTH];

    logic [slt_pkg::CMD_W-1:0]        r_cmd;
    logic signed [slt_pkg::VAL_W-1:0] r_val, n_val;
    logic [slt_pkg::CNT_W-1:0]        r_count, n_count;
    logic [slt_pkg::IDX_W-1:0]        r_idx, n_idx;
    logic                             r_found, n_found;
    logic [slt_pkg::IDX_W-1:0]        r_hpos, n_hpos;
    logic signed [slt_pkg::VAL_W-1:0] r_hval, n_hval;
    logic signed [slt_pkg::VAL_W-1:0] r_rdata;
    slt_pkg::t_result                 r_res, n_res;

    logic                             rd_en;
    logic [slt_pkg::IDX_W-1:0]        rd_addr;
    logic                             wr_en;
    logic [slt_pkg::IDX_W-1:0]        wr_addr;
    logic signed [slt_pkg::VAL_W-1:0] wr_data;
    logic                             quick;
    logic                             done;

    // Per-command walk decisions.
    always_comb begin
        logic [slt_pkg::CNT_W-1:0] count_m1;
        logic                      is_valid;
        logic                      is_find;
        logic                      last;
        logic                      hit;
        logic                      found_now;

        count_m1  = r_count - slt_pkg::CNT_W'(1);
        is_valid  = (r_cmd inside {[slt_pkg::CMD_INSERT:slt_pkg::CMD_SEARCH]});
        is_find   = (r_cmd inside {slt_pkg::CMD_POP_HEAD, slt_pkg::CMD_REMOVE,
                                   slt_pkg::CMD_SEARCH});
        last      = (slt_pkg::CNT_W'(r_idx) == count_m1);
        hit       = !r_found && ((r_cmd == slt_pkg::CMD_POP_HEAD) || (r_rdata == r_val));
        found_now = r_found || hit;

        n_val   = r_val;
        n_count = r_count;
        n_idx   = r_idx;
        n_found = r_found;
        n_hpos  = r_hpos;
        n_hval  = r_hval;
        n_res   = r_res;
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = r_rdata;
        quick   = 1'b0;
        done    = 1'b0;

        if (i_ctrl.load) begin
            n_val = i_request.item_value;
        end

        if (i_ctrl.prep) begin
            quick = !is_valid
                 || ((r_cmd == slt_pkg::CMD_INSERT) && (r_count == slt_pkg::CNT_W'(slt_pkg::DEPTH)))
                 || ((r_cmd != slt_pkg::CMD_INSERT) && (r_count == '0));
            n_res.position    = '0;
            n_res.entry_count = slt_pkg::COUNT_W'(r_count);
            if (!is_valid) begin
                n_res.status       = slt_pkg::ST_OK;
                n_res.result_value = '0;
            end else if (r_cmd == slt_pkg::CMD_INSERT) begin
                n_res.status       = slt_pkg::ST_FULL;
                n_res.result_value = r_val;
            end else begin
                n_res.status       = slt_pkg::ST_EMPTY;
                n_res.result_value = '0;
            end
            // First read of the walk: tail side for insert and pop tail, head for a find.
            rd_en   = 1'b1;
            n_found = 1'b0;
            if (is_find) begin
                rd_addr = '0;
                n_idx   = '0;
            end else begin
                rd_addr = count_m1[slt_pkg::IDX_W-1:0];
                n_idx   = r_count[slt_pkg::IDX_W-1:0];
            end
        end

        if (i_ctrl.step) begin
            n_res.status = slt_pkg::ST_OK;
            if (r_cmd == slt_pkg::CMD_INSERT) begin
                // Move larger entries up one slot until the new value fits.
                wr_en   = 1'b1;
                wr_addr = r_idx;
                if ((r_idx == '0) || !(r_rdata > r_val)) begin
                    wr_data            = r_val;
                    done               = 1'b1;
                    n_count            = r_count + slt_pkg::CNT_W'(1);
                    n_res.position     = slt_pkg::POS_W'(r_idx);
                    n_res.result_value = r_val;
                    n_res.entry_count  = slt_pkg::COUNT_W'(r_count + slt_pkg::CNT_W'(1));
                end else begin
                    wr_data = r_rdata;
                    n_idx   = r_idx - slt_pkg::IDX_W'(1);
                    rd_en   = 1'b1;
                    rd_addr = r_idx - slt_pkg::IDX_W'(1) - slt_pkg::IDX_W'(1);
                end
            end else if (r_cmd == slt_pkg::CMD_POP_TAIL) begin
                done               = 1'b1;
                n_count            = count_m1;
                n_res.position     = slt_pkg::POS_W'(count_m1);
                n_res.result_value = r_rdata;
                n_res.entry_count  = slt_pkg::COUNT_W'(count_m1);
            end else begin
                // Scan from the head; after the match, pop head and remove close the gap one slot at a time.
                n_found = found_now;
                if (hit) begin
                    n_hpos = r_idx;
                    n_hval = r_rdata;
                end
                if (r_found) begin
                    wr_en   = 1'b1;
                    wr_addr = r_idx - slt_pkg::IDX_W'(1);
                    wr_data = r_rdata;
                end
                rd_en   = 1'b1;
                rd_addr = r_idx + slt_pkg::IDX_W'(1);
                n_idx   = r_idx + slt_pkg::IDX_W'(1);
                done    = last || ((r_cmd == slt_pkg::CMD_SEARCH) && hit);
                if (found_now) begin
                    n_res.position     = slt_pkg::POS_W'(hit ? r_idx : r_hpos);
                    n_res.result_value = hit ? r_rdata : r_hval;
                    if (r_cmd == slt_pkg::CMD_SEARCH) begin
                        n_res.entry_count = slt_pkg::COUNT_W'(r_count);
                    end else begin
                        n_res.entry_count = slt_pkg::COUNT_W'(count_m1);
                        if (done) begin
                            n_count = count_m1;
                        end
                    end
                end else begin
                    n_res.status       = slt_pkg::ST_NOT_FOUND;
                    n_res.position     = '0;
                    n_res.result_value = r_val;
                    n_res.entry_count  = slt_pkg::COUNT_W'(r_count);
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_found <= 1'b0;
            r_cmd   <= slt_pkg::CMD_INSERT;
        end else begin
            r_count <= n_count;
            r_found <= n_found;
            if (i_ctrl.load) begin
                r_cmd <= i_request.command;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_idx  <= n_idx;
        r_hpos <= n_hpos;
        r_hval <= n_hval;
        r_res  <= n_res;
    end

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    assign o_stat.quick = quick;
    assign o_stat.done  = done;
    assign o_result     = r_res;

endmodule

FILE: rtl/slt_controller.sv
module slt_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  slt_pkg::t_dp_stat i_stat,
    output slt_pkg::t_dp_ctrl o_ctrl,
    output logic              o_busy,
    output logic              o_strobe
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_WALK
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_strobe;

    // Load follows a start while not busy; prep and step follow the current state.
    assign o_ctrl.load = i_start && !r_busy;
    assign o_ctrl.prep = (r_state == S_PREP);
    assign o_ctrl.step = (r_state == S_WALK);

    // Sequencer with registered busy and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_PREP;
                        r_busy  <= 1'b1;
                    end
                end
                S_PREP: begin
                    if (i_stat.quick) begin
                        r_state  <= S_IDLE;
                        r_busy   <= 1'b0;
                        r_strobe <= 1'b1;
                    end else begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (i_stat.done) begin
                        r_state  <= S_IDLE;
                        r_busy   <= 1'b0;
                        r_strobe <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign o_busy   = r_busy;
    assign o_strobe = r_strobe;

endmodule

FILE: rtl/slt_checker.sv
`include "sorted_list_table_core_defines.svh"

module slt_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic              o_busy,
    input logic              o_strobe,
    input slt_pkg::t_result  o_result
);

    logic req_taken;
    logic full_res;

    assign req_taken = i_start && !o_busy;
    assign full_res  = o_strobe && (o_result.status == slt_pkg::ST_FULL);

    // A taken request makes the block busy on the next cycle.
    `SLT_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, req_taken, o_busy)

    // A result only ends a busy period.
    `SLT_ASSERT_IMPLY(a_strobe_after_busy, i_clk, i_rst_n, o_strobe, $past(o_busy))

    // Two results never come in back-to-back cycles.
    `SLT_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_strobe, !o_strobe)

    // A full report shows a table holding every slot.
    `SLT_ASSERT_IMPLY(a_full_count, i_clk, i_rst_n, full_res,
        o_result.entry_count == slt_pkg::COUNT_W'(slt_pkg::DEPTH))

    // The reported occupancy never passes the table size.
    `SLT_ASSERT_IMPLY(a_count_range, i_clk, i_rst_n, o_strobe,
        o_result.entry_count <= slt_pkg::COUNT_W'(slt_pkg::DEPTH))

endmodule

bind sorted_list_table_core slt_checker u_slt_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_start   (i_start),
    .o_busy    (o_busy),
    .o_strobe  (o_strobe),
    .o_result  (o_result)
);

FILE: dv/tb_sorted_list_table_core.sv
`timescale 1ns / 100ps

import slt_pkg::*;

// Scoreboard with its own copy of the sorted table.
class sorted_list_scoreboard;

    localparam int MAX_REPORTS = 40;

    logic signed [VAL_W-1:0] held_values[$];
    t_result                 pending_results[$];
    int                      errors;
    int                      checked;
    int                      status_seen[4];
    int                      full_reached;

    function new();
        errors       = 0;
        checked      = 0;
        full_reached = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // Apply one accepted request to the table copy and queue its result.
    function void note_request(t_request req);
        t_result                 res;
        logic signed [VAL_W-1:0] val;
        int                      pos;
        int                      found;

        val   = req.item_value;
        res   = '0;
        pos   = 0;
        found = -1;
        case (req.command)
            CMD_INSERT: begin
                res.result_value = val;
                if (held_values.size() >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    // Equal values go after the ones already held.
                    pos = held_values.size();
                    for (int i = 0; i < held_values.size(); i++) begin
                        if (held_values[i] > val) begin
                            pos = i;
                            break;
                        end
                    end
                    held_values.insert(pos, val);
                    res.status   = ST_OK;
                    res.position = pos[POS_W-1:0];
                    if (held_values.size() == DEPTH) full_reached++;
                end
            end
            CMD_POP_HEAD, CMD_POP_TAIL, CMD_REMOVE, CMD_SEARCH: begin
                if (held_values.size() == 0) begin
                    res.status = ST_EMPTY;
                end else if (req.command == CMD_POP_HEAD) begin
                    res.result_value = held_values.pop_front();
                end else if (req.command == CMD_POP_TAIL) begin
                    pos              = held_values.size() - 1;
                    res.position     = pos[POS_W-1:0];
                    res.result_value = held_values.pop_back();
                end else begin
                    for (int i = 0; i < held_values.size(); i++) begin
                        if (held_values[i] == val) begin
                            found = i;
                            break;
                        end
                    end
                    res.result_value = val;
                    if (found < 0) begin
                        res.status = ST_NOT_FOUND;
                    end else begin
                        res.position = found[POS_W-1:0];
                        if (req.command == CMD_REMOVE) held_values.delete(found);
                    end
                end
            end
            default: begin
                // Unused command codes leave the table alone.
            end
        endcase
        pos             = held_values.size();
        res.entry_count = pos[COUNT_W-1:0];
        pending_results.push_back(res);
    endfunction

    // Compare one result from the block with the oldest expectation.
    function void check_result(t_result got);
        t_result exp;
        bit      bad;

        if (pending_results.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: unexpected result, got status %0d pos %0d value %0d count %0d",
                         $time, got.status, got.position, got.result_value,
                         got.entry_count);
            return;
        end
        exp = pending_results.pop_front();
        checked++;
        status_seen[exp.status]++;
        bad = 0;
        if (got.status !== exp.status) begin
            bad = 1;
            if (errors < MAX_REPORTS)
                $display("%0t: status mismatch, expected %0d, got %0d",
                         $time, exp.status, got.status);
        end
        if (got.position !== exp.position) begin
            bad = 1;
            if (errors < MAX_REPORTS)
                $display("%0t: position mismatch, expected %0d, got %0d",
                         $time, exp.position, got.position);
        end
        if (got.result_value !== exp.result_value) begin
            bad = 1;
            if (errors < MAX_REPORTS)
                $display("%0t: value mismatch, expected %0d, got %0d",
                         $time, exp.result_value, got.result_value);
        end
        if (got.entry_count !== exp.entry_count) begin
            bad = 1;
            if (errors < MAX_REPORTS)
                $display("%0t: count mismatch, expected %0d, got %0d",
                         $time, exp.entry_count, got.entry_count);
        end
        if (bad) errors++;
    endfunction

    function int pending_count();
        return pending_results.size();
    endfunction

endclass

module tb_sorted_list_table_core;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int DRAIN_CYCLES     = 50;
    localparam int ITEMS_PER_PHASE  = 290;
    localparam int MODE_SPAN        = 60;
    localparam logic [CMD_W-1:0] CMD_RESERVED_LO = CMD_SEARCH + 3'd1;
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    // Table usage modes for the random part.
    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} t_mode;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_start;
    t_request i_request;
    logic     o_busy;
    logic     o_strobe;
    t_result  o_result;

    sorted_list_scoreboard list_sb;
    int                    cycle_count;
    int                    requests_sent;

    sorted_list_table_core u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_request (i_request),
        .o_busy    (o_busy),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Watchdog on the total run length.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sorted_list_table_core test failed");
            $finish;
        end
    end

    // Results are sampled on the edge that ends the strobe cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) list_sb.check_result(o_result);
    end

    // Present one request, with an optional idle gap first, and wait for it to be taken.
    task automatic drive_request(input t_request req, input int idle_pct);
        int gap;

        if ($urandom_range(99) < idle_pct) begin
            gap     = $urandom_range(1, 24);
            i_start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start   = 1'b1;
        i_request = req;
        do @(posedge i_clk); while (o_busy);
        list_sb.note_request(req);
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic signed [VAL_W-1:0] val);
        t_request req;

        req.command    = cmd;
        req.item_value = val;
        drive_request(req, 0);
    endtask

    // Values are drawn so that duplicates and hits on held entries are common.
    function automatic logic signed [VAL_W-1:0] pick_value();
        int sel;
        int n;

        sel = $urandom_range(9);
        n   = list_sb.held_values.size();
        if (sel <= 3) return $signed($urandom_range(0, 7)) - 4;
        if (sel <= 5 && n > 0) return list_sb.held_values[$urandom_range(0, n - 1)];
        if (sel == 9) begin
            case ($urandom_range(3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return 0;
                default: return -1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(input t_mode mode);
        int roll;
        int insert_pct;

        insert_pct = (mode == MODE_FILL) ? 60 : (mode == MODE_DRAIN) ? 15 : 35;
        roll = $urandom_range(99);
        if (roll < 3) return CMD_RESERVED_LO + 3'($urandom_range(0, 2));
        if (roll < 3 + insert_pct) return CMD_INSERT;
        case ($urandom_range(3))
            0: return CMD_POP_HEAD;
            1: return CMD_POP_TAIL;
            2: return CMD_REMOVE;
            default: return CMD_SEARCH;
        endcase
    endfunction

    // Main sequence.
    initial begin
        int       idle_pct[4];
        t_mode    mode;
        t_request req;

        list_sb       = new();
        requests_sent = 0;
        idle_pct      = '{0, 47, 0, 33};
        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_request     = '0;
        mode          = MODE_FILL;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Pop head, pop tail, remove and search on an empty table, then the unused codes.
        send_cmd(CMD_POP_HEAD, 0);
        send_cmd(CMD_POP_TAIL, 0);
        send_cmd(CMD_REMOVE, 5);
        send_cmd(CMD_SEARCH, 5);
        for (int c = CMD_RESERVED_LO; c <= 7; c++) send_cmd(c[CMD_W-1:0], VAL_MAX);

        // Extremes of the value range, with duplicates at the middle and the tail.
        send_cmd(CMD_INSERT, 0);
        send_cmd(CMD_INSERT, VAL_MAX);
        send_cmd(CMD_INSERT, VAL_MIN);
        send_cmd(CMD_INSERT, -1);
        send_cmd(CMD_INSERT, 0);
        send_cmd(CMD_INSERT, VAL_MAX);

        // Hits and misses for search and remove, then both pops and a last search.
        send_cmd(CMD_SEARCH, 0);
        send_cmd(CMD_SEARCH, 42);
        send_cmd(CMD_SEARCH, VAL_MIN);
        send_cmd(CMD_REMOVE, 0);
        send_cmd(CMD_REMOVE, 42);
        send_cmd(CMD_POP_HEAD, 0);
        send_cmd(CMD_POP_TAIL, 0);
        send_cmd(CMD_SEARCH, VAL_MAX);

        // Random part, one idle pattern per phase.
        for (int phase = 0; phase < 4; phase++) begin
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k % MODE_SPAN == 0) mode = t_mode'($urandom_range(0, 2));
                req.command    = pick_command(mode);
                req.item_value = pick_value();
                drive_request(req, idle_pct[phase]);
            end
        end
        i_start = 1'b0;

        while (list_sb.pending_count() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d of %0d requests: %0d ok, %0d empty, %0d not found, %0d full.",
                 list_sb.checked, requests_sent, list_sb.status_seen[ST_OK],
                 list_sb.status_seen[ST_EMPTY], list_sb.status_seen[ST_NOT_FOUND],
                 list_sb.status_seen[ST_FULL]);
        $display("The table filled to its depth %0d times; %0d mismatches seen.",
                 list_sb.full_reached, list_sb.errors);
        if (list_sb.errors == 0 && list_sb.pending_count() == 0) begin
            $display("sorted_list_table_core test passed");
        end else begin
            $display("sorted_list_table_core test failed");
        end
        $finish;
    end

endmodule
